// ===== src/battery_and_remote_key_classifier_unit_assert.svh =====
// ----------------------------------------------------------------------------
// battery_and_remote_key_classifier_unit_assert: assertion macros
// Assertion macros shared by the classifier RTL. Every macro samples on the
// rising edge of clk_i and is switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BATTERY_AND_REMOTE_KEY_CLASSIFIER_UNIT_ASSERT_SVH
`define BATTERY_AND_REMOTE_KEY_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BRKC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRKC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/brkc_pkg.sv =====
// ----------------------------------------------------------------------------
// brkc_pkg: shared types and constants of the battery and remote classifier
// Widths, command and result codes, configuration record and key windows.
// ----------------------------------------------------------------------------
package brkc_pkg;

  localparam int unsigned SAMPLE_WIDTH = 10;
  // Compare width: holds a sample plus offset and every 11-bit threshold.
  localparam int unsigned CMP_W = (SAMPLE_WIDTH + 1 > 11) ? SAMPLE_WIDTH + 1 : 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_KEY_WIN = 7;

  typedef enum logic [1:0] {
    CMD_BATTERY = 2'd0,
    CMD_DETECT  = 2'd1,
    CMD_KEY     = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    LVL_HIGH  = 3'd0,
    LVL_MID   = 3'd1,
    LVL_LOW   = 3'd2,
    LVL_EMPTY = 3'd3,
    LVL_OLD   = 3'd4
  } lvl_e;

  typedef enum logic [3:0] {
    KEY_NONE     = 4'd0,
    KEY_EQ       = 4'd1,
    KEY_VOL_UP   = 4'd2,
    KEY_VOL_DOWN = 4'd3,
    KEY_PLAY     = 4'd4,
    KEY_REW      = 4'd5,
    KEY_FF       = 4'd6,
    KEY_NEXT     = 4'd7,
    KEY_REMOVED  = 4'd8
  } key_e;

  typedef enum logic [2:0] {
    REG_BAT_OFFSET   = 3'd0,
    REG_BAT_HIGH     = 3'd1,
    REG_BAT_MID      = 3'd2,
    REG_BAT_LOW      = 3'd3,
    REG_BAT_MAX      = 3'd4,
    REG_BAT_STABLE   = 3'd5,
    REG_DET_COUNT    = 3'd6,
    REG_DET_ATTEMPTS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [5:0]  bat_offset;
    logic [10:0] bat_high;
    logic [10:0] bat_mid;
    logic [10:0] bat_low;
    logic [3:0]  bat_max;
    logic [3:0]  bat_stable;
    logic [3:0]  det_count;
    logic [3:0]  det_attempts;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    bat_offset:   6'd0,
    bat_high:     11'd832,
    bat_mid:      11'd720,
    bat_low:      11'd608,
    bat_max:      4'd10,
    bat_stable:   4'd4,
    det_count:    4'd5,
    det_attempts: 4'd10
  };

  typedef struct packed {
    lvl_e level;
    logic done;
  } bat_res_t;

  typedef struct packed {
    key_e key;
    logic present;
    logic detect_done;
  } rem_res_t;

  // Remote voltage limits.
  localparam logic [CMP_W-1:0] DET_WIN_LO = CMP_W'(12'h315);
  localparam logic [CMP_W-1:0] DET_WIN_HI = CMP_W'(12'h350);
  localparam logic [CMP_W-1:0] KEY_MIN    = CMP_W'(12'h060);
  localparam logic [CMP_W-1:0] KEY_MAX    = CMP_W'(12'h350);
  localparam logic [CMP_W-1:0] KEY_CEIL   = CMP_W'(12'h2EA);

  typedef struct packed {
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
    key_e             key;
  } key_win_t;

  // Key windows in priority order, both bounds exclusive.
  localparam key_win_t KEY_WIN [NUM_KEY_WIN] = '{
    '{lo: CMP_W'(12'h2C5), hi: CMP_W'(12'h2DC), key: KEY_VOL_UP},
    '{lo: CMP_W'(12'h267), hi: CMP_W'(12'h27B), key: KEY_VOL_DOWN},
    '{lo: CMP_W'(12'h1FA), hi: CMP_W'(12'h20D), key: KEY_EQ},
    '{lo: CMP_W'(12'h193), hi: CMP_W'(12'h1A6), key: KEY_FF},
    '{lo: CMP_W'(12'h130), hi: CMP_W'(12'h140), key: KEY_PLAY},
    '{lo: CMP_W'(12'h0D5), hi: CMP_W'(12'h0E5), key: KEY_REW},
    '{lo: CMP_W'(12'h06A), hi: CMP_W'(12'h08A), key: KEY_NEXT}
  };

endpackage

// ===== src/brkc_if.sv =====
// ----------------------------------------------------------------------------
// brkc_if: handshake channels of the battery and remote classifier
// Sample input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface brkc_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic [brkc_pkg::SAMPLE_WIDTH-1:0] sample;
  logic                              first;

  modport source (output valid, command, sample, first, input ready);
  modport sink (input valid, command, sample, first, output ready);
endinterface

interface brkc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] battery_level;
  logic       battery_done;
  logic [3:0] remote_key;
  logic       remote_present;
  logic       detect_done;

  modport source (output valid, battery_level, battery_done, remote_key,
                  remote_present, detect_done, input ready);
  modport sink (input valid, battery_level, battery_done, remote_key,
                remote_present, detect_done, output ready);
endinterface

interface brkc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [brkc_pkg::CFG_IDX_W-1:0]  index;
  logic [brkc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/brkc_battery.sv =====
// ----------------------------------------------------------------------------
// brkc_battery: battery burst tracker
// Classifies one battery sample and keeps the stable-level burst state.
// ----------------------------------------------------------------------------
module brkc_battery (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [brkc_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                              first_i,
  input  brkc_pkg::cfg_t                    cfg_i,
  output brkc_pkg::bat_res_t                res_o
);

  logic [1:0] prev_q, prev_d;
  logic [3:0] stable_q, stable_d;
  logic [3:0] index_q, index_d;
  logic       decided_q, decided_d;

  logic [brkc_pkg::CMP_W-1:0] sum;
  logic [1:0]                 lvl;
  brkc_pkg::lvl_e             res_lvl;

  assign sum = brkc_pkg::CMP_W'(sample_i) + brkc_pkg::CMP_W'(cfg_i.bat_offset);

  always_comb begin
    if (sum > brkc_pkg::CMP_W'(cfg_i.bat_high)) begin
      lvl = 2'd0;
    end else if (sum > brkc_pkg::CMP_W'(cfg_i.bat_mid)) begin
      lvl = 2'd1;
    end else if (sum > brkc_pkg::CMP_W'(cfg_i.bat_low)) begin
      lvl = 2'd2;
    end else begin
      lvl = 2'd3;
    end
  end

  always_comb begin
    prev_d    = prev_q;
    stable_d  = stable_q;
    index_d   = index_q;
    decided_d = decided_q;
    res_lvl   = brkc_pkg::LVL_OLD;
    if (en_i) begin
      if (first_i) begin
        prev_d    = lvl;
        stable_d  = 4'd0;
        index_d   = 4'd0;
        decided_d = (cfg_i.bat_max == 4'd0);
      end else if (!decided_q) begin
        index_d = index_q + 4'd1;
        if (stable_q == cfg_i.bat_stable) begin
          decided_d = 1'b1;
          res_lvl   = brkc_pkg::lvl_e'({1'b0, lvl});
        end else begin
          stable_d  = (lvl == prev_q) ? stable_q + 4'd1 : 4'd0;
          prev_d    = lvl;
          decided_d = (index_d >= cfg_i.bat_max);
        end
      end
    end
  end

  assign res_o.level = res_lvl;
  assign res_o.done  = decided_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 2'd0;
      stable_q  <= 4'd0;
      index_q   <= 4'd0;
      decided_q <= 1'b1;
    end else begin
      prev_q    <= prev_d;
      stable_q  <= stable_d;
      index_q   <= index_d;
      decided_q <= decided_d;
    end
  end

endmodule

// ===== src/brkc_remote.sv =====
// ----------------------------------------------------------------------------
// brkc_remote: earphone remote presence and key decoder
// Runs detection bursts, decodes key samples and holds the presence flag.
// ----------------------------------------------------------------------------
module brkc_remote (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  brkc_pkg::cmd_e                    cmd_i,
  input  logic [brkc_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                              first_i,
  input  brkc_pkg::cfg_t                    cfg_i,
  output brkc_pkg::rem_res_t                res_o
);

  logic       present_q, present_d;
  logic [3:0] match_q, match_d;
  logic [3:0] attempt_q, attempt_d;
  logic       finished_q, finished_d;

  logic [brkc_pkg::CMP_W-1:0] s;
  logic                       in_det_win;
  logic                       out_of_range;
  brkc_pkg::key_e             win_key;
  brkc_pkg::key_e             key;
  logic [3:0]                 match_base;
  logic                       found;

  assign s            = brkc_pkg::CMP_W'(sample_i);
  assign in_det_win   = (s > brkc_pkg::DET_WIN_LO) && (s < brkc_pkg::DET_WIN_HI);
  assign out_of_range = (s < brkc_pkg::KEY_MIN) || (s > brkc_pkg::KEY_MAX);

  // Windows do not overlap; the first hit wins.
  always_comb begin
    win_key = brkc_pkg::KEY_NONE;
    found   = 1'b0;
    for (int i = 0; i < brkc_pkg::NUM_KEY_WIN; i++) begin
      if (!found && s > brkc_pkg::KEY_WIN[i].lo && s < brkc_pkg::KEY_WIN[i].hi) begin
        win_key = brkc_pkg::KEY_WIN[i].key;
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    present_d  = present_q;
    match_d    = match_q;
    attempt_d  = attempt_q;
    finished_d = finished_q;
    key        = brkc_pkg::KEY_NONE;
    match_base = first_i ? 4'd0 : match_q;
    if (en_i) begin
      case (cmd_i)
        brkc_pkg::CMD_DETECT: begin
          if (first_i) begin
            match_d    = 4'd0;
            attempt_d  = 4'd0;
            finished_d = 1'b0;
          end
          if (first_i && present_q) begin
            finished_d = 1'b1;
          end else if (first_i || !finished_q) begin
            attempt_d = (first_i ? 4'd0 : attempt_q) + 4'd1;
            if (in_det_win && match_base == cfg_i.det_count) begin
              present_d  = 1'b1;
              finished_d = 1'b1;
            end else begin
              match_d    = in_det_win ? match_base + 4'd1 : 4'd0;
              finished_d = (attempt_d >= cfg_i.det_attempts);
            end
          end
        end
        brkc_pkg::CMD_KEY: begin
          if (!present_q) begin
            key = brkc_pkg::KEY_REMOVED;
          end else if (out_of_range) begin
            present_d = 1'b0;
            key       = brkc_pkg::KEY_REMOVED;
          end else if (s > brkc_pkg::KEY_CEIL) begin
            key = brkc_pkg::KEY_NONE;
          end else begin
            key = win_key;
          end
        end
        brkc_pkg::CMD_CLEAR: begin
          present_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.key         = key;
  assign res_o.present     = present_d;
  assign res_o.detect_done = finished_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= 1'b0;
      match_q    <= 4'd0;
      attempt_q  <= 4'd0;
      finished_q <= 1'b1;
    end else begin
      present_q  <= present_d;
      match_q    <= match_d;
      attempt_q  <= attempt_d;
      finished_q <= finished_d;
    end
  end

endmodule

// ===== src/battery_and_remote_key_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// battery_and_remote_key_classifier_unit: converter sample classifier
// Battery level bursts, earphone remote detection and remote key decoding.
// ----------------------------------------------------------------------------
// Each input transaction carries a command, a converter sample and a burst
// start flag, and produces exactly one result transaction holding the battery
// level, the battery burst state, the decoded remote key, the presence flag
// and the detection burst state. The block accepts one transaction per clock
// cycle unless a stalled result holds a full input register. A transaction
// passes through the input register; the classification logic and the
// state update then land in the result register at the same edge, so the
// following sample sees the updated burst and presence state at once.
// Configuration writes are always accepted (ready is tied high) and must be
// issued only while no transaction is in flight.
`include "battery_and_remote_key_classifier_unit_assert.svh"

module battery_and_remote_key_classifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  brkc_in_if.sink    in_i,
  brkc_out_if.source out_o,
  brkc_cfg_if.sink   cfg_i
);

  // Configuration registers.
  brkc_pkg::cfg_t cfg_q;

  // Input register stage.
  logic                              in_vld_q;
  brkc_pkg::cmd_e                    in_cmd_q;
  logic [brkc_pkg::SAMPLE_WIDTH-1:0] in_sample_q;
  logic                              in_first_q;

  // Result register stage.
  logic           out_vld_q;
  brkc_pkg::lvl_e out_lvl_q;
  logic           out_bat_done_q;
  brkc_pkg::key_e out_key_q;
  logic           out_present_q;
  logic           out_det_done_q;

  logic               advance;
  logic               bat_en;
  brkc_pkg::bat_res_t bat_res;
  brkc_pkg::rem_res_t rem_res;

  // The input stage moves forward whenever the result register is free or
  // is being emptied in this cycle, so a result taken in the same cycle does
  // not hold up intake of the next sample. Only a stalled result with a full
  // input stage blocks the input.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign bat_en     = advance && (in_cmd_q == brkc_pkg::CMD_BATTERY);

  assign cfg_i.ready = 1'b1;

  // Configuration write; the register bits above each field's width are
  // dropped, as are writes that fall outside the list (none with 3 bits).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= brkc_pkg::CFG_RESET;
    end else if (cfg_i.valid) begin
      case (brkc_pkg::reg_idx_e'(cfg_i.index))
        brkc_pkg::REG_BAT_OFFSET:   cfg_q.bat_offset   <= cfg_i.data[5:0];
        brkc_pkg::REG_BAT_HIGH:     cfg_q.bat_high     <= cfg_i.data[10:0];
        brkc_pkg::REG_BAT_MID:      cfg_q.bat_mid      <= cfg_i.data[10:0];
        brkc_pkg::REG_BAT_LOW:      cfg_q.bat_low      <= cfg_i.data[10:0];
        brkc_pkg::REG_BAT_MAX:      cfg_q.bat_max      <= cfg_i.data[3:0];
        brkc_pkg::REG_BAT_STABLE:   cfg_q.bat_stable   <= cfg_i.data[3:0];
        brkc_pkg::REG_DET_COUNT:    cfg_q.det_count    <= cfg_i.data[3:0];
        brkc_pkg::REG_DET_ATTEMPTS: cfg_q.det_attempts <= cfg_i.data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: valid flag under reset, payload loaded on acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_cmd_q    <= brkc_pkg::cmd_e'(in_i.command);
      in_sample_q <= in_i.sample;
      in_first_q  <= in_i.first;
    end
  end

  brkc_battery u_battery (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (bat_en),
    .sample_i (in_sample_q),
    .first_i  (in_first_q),
    .cfg_i    (cfg_q),
    .res_o    (bat_res)
  );

  brkc_remote u_remote (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .cmd_i    (in_cmd_q),
    .sample_i (in_sample_q),
    .first_i  (in_first_q),
    .cfg_i    (cfg_q),
    .res_o    (rem_res)
  );

  // Result register. The battery level only means something for a battery
  // sample and the key only for a key sample; the remote module already
  // reports no key for every other command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_lvl_q      <= bat_en ? bat_res.level : brkc_pkg::LVL_OLD;
      out_bat_done_q <= bat_res.done;
      out_key_q      <= rem_res.key;
      out_present_q  <= rem_res.present;
      out_det_done_q <= rem_res.detect_done;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.battery_level  = out_lvl_q;
  assign out_o.battery_done   = out_bat_done_q;
  assign out_o.remote_key     = out_key_q;
  assign out_o.remote_present = out_present_q;
  assign out_o.detect_done    = out_det_done_q;

  // A reported level always closes the burst.
  `BRKC_ASSERT_IMP(a_level_closes_burst,
                   out_vld_q && out_lvl_q != brkc_pkg::LVL_OLD, out_bat_done_q,
                   "battery level reported while burst still open")

  // A decoded key is only possible while the remote is present.
  `BRKC_ASSERT_IMP(a_key_needs_presence,
                   out_vld_q && out_key_q != brkc_pkg::KEY_NONE &&
                   out_key_q != brkc_pkg::KEY_REMOVED, out_present_q,
                   "key decoded without remote presence")

  // A removal report always leaves presence cleared.
  `BRKC_ASSERT_IMP(a_removed_clears_presence,
                   out_vld_q && out_key_q == brkc_pkg::KEY_REMOVED, !out_present_q,
                   "removal reported with presence still set")

  // A sample held in the input stage by a stalled result stays put.
  `BRKC_ASSERT_NXT(a_input_stage_holds,
                   in_vld_q && !advance, in_vld_q && $stable(in_sample_q),
                   "input stage lost or changed a waiting sample")

endmodule
